// File: rtl/core/csb_pkg.sv
package csb_pkg;

	localparam int DEPTH  = 64;
	localparam int WORD_W = 32;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int GRP    = 8;
	localparam int NGRP   = (DEPTH + GRP - 1) / GRP;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	localparam logic [2:0] MODE_RESTART = 3'd0;
	localparam logic [2:0] MODE_ADVANCE = 3'd1;
	localparam logic [2:0] MODE_INSERT  = 3'd2;
	localparam logic [2:0] MODE_ATTACH  = 3'd3;
	localparam logic [2:0] MODE_REMOVE  = 3'd4;
	localparam logic [2:0] MODE_QUERY   = 3'd5;

	localparam logic [1:0] OP_HOLD   = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	typedef struct packed {
		logic [1:0] op;
		idx_t       pos;
		word_t      value;
	} cell_cmd_t;

endpackage

// File: rtl/core/csb_cell.sv
module csb_cell (
	input  logic               clk,
	input  csb_pkg::cell_cmd_t cmd,
	input  csb_pkg::idx_t      idx,
	input  csb_pkg::word_t     left_word,
	input  csb_pkg::word_t     right_word,
	output csb_pkg::word_t     word
);
	import csb_pkg::*;

	word_t word_q;

	// Insert opens a gap at pos by pulling from the left; remove closes it by pulling from the right.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_INSERT: begin
				if (idx > cmd.pos) begin
					word_q <= left_word;
				end else if (idx == cmd.pos) begin
					word_q <= cmd.value;
				end
			end
			OP_REMOVE: begin
				if (idx >= cmd.pos) begin
					word_q <= right_word;
				end
			end
			default: begin
			end
		endcase
	end

	assign word = word_q;

endmodule

// File: rtl/core/csb_ctrl.sv
module csb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [2:0]         mode,
	input  csb_pkg::word_t     value,
	output csb_pkg::cell_cmd_t cmd,
	output csb_pkg::cnt_t      cursor,
	output csb_pkg::cnt_t      count,
	output logic               rejected
);
	import csb_pkg::*;

	cnt_t cursor_q, count_q, cursor_d, count_d, cur_inc;
	logic rejected_q, rejected_d;
	logic present, full;

	assign present = cursor_q < count_q;
	assign full    = count_q >= CNT_W'(DEPTH);
	assign cur_inc = cursor_q + CNT_W'(1);

	always_comb begin
		cursor_d   = cursor_q;
		count_d    = count_q;
		rejected_d = rejected_q;
		cmd.op     = OP_HOLD;
		cmd.pos    = '0;
		cmd.value  = value;
		if (accept) begin
			rejected_d = 1'b0;
			unique case (mode)
				MODE_RESTART: begin
					cursor_d = '0;
				end
				MODE_ADVANCE: begin
					if (present) begin
						cursor_d = cur_inc;
					end
				end
				MODE_INSERT: begin
					if (full) begin
						rejected_d = 1'b1;
					end else begin
						// With no current item the new item goes to the front.
						cmd.op   = OP_INSERT;
						cmd.pos  = present ? cursor_q[IDX_W-1:0] : '0;
						cursor_d = present ? cursor_q : '0;
						count_d  = count_q + CNT_W'(1);
					end
				end
				MODE_ATTACH: begin
					if (full) begin
						rejected_d = 1'b1;
					end else begin
						cmd.op   = OP_INSERT;
						cmd.pos  = present ? cur_inc[IDX_W-1:0] : count_q[IDX_W-1:0];
						cursor_d = present ? cur_inc : count_q;
						count_d  = count_q + CNT_W'(1);
					end
				end
				MODE_REMOVE: begin
					if (present) begin
						cmd.op  = OP_REMOVE;
						cmd.pos = cursor_q[IDX_W-1:0];
						count_d = count_q - CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q   <= '0;
			count_q    <= '0;
			rejected_q <= 1'b0;
		end else begin
			cursor_q   <= cursor_d;
			count_q    <= count_d;
			rejected_q <= rejected_d;
		end
	end

	assign cursor   = cursor_q;
	assign count    = count_q;
	assign rejected = rejected_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("stored count beyond depth");
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= count_q)
		else $error("cursor beyond stored count");
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (mode == MODE_INSERT || mode == MODE_ATTACH) && !full
		|=> count_q == $past(count_q) + CNT_W'(1))
		else $error("accepted insert did not grow the store");
	a_reject_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		accept && full && (mode == MODE_INSERT || mode == MODE_ATTACH)
		|=> $stable(count_q))
		else $error("store changed while full");
`endif

endmodule

// File: rtl/core/csb_select.sv
module csb_select (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  csb_pkg::word_t words [csb_pkg::DEPTH],
	input  csb_pkg::cnt_t  cursor,
	input  csb_pkg::cnt_t  count_in,
	input  logic           rejected_in,
	output logic           busy,
	output logic           done,
	output csb_pkg::word_t current_value,
	output logic           has_item,
	output csb_pkg::cnt_t  count,
	output logic           rejected
);
	import csb_pkg::*;

	logic         acc_s1, sel_s2, done_q;
	logic [DEPTH-1:0] hit;
	word_t        grp_d [NGRP];
	word_t        grp_s2 [NGRP];
	word_t        final_d;
	word_t        value_q;
	logic         has_q, rej_q;
	cnt_t         count_q;

	// One-hot pick of the cursor cell, reduced in two registered levels.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			hit[i] = (cursor == CNT_W'(i));
		end
		for (int g = 0; g < NGRP; g++) begin
			grp_d[g] = '0;
			for (int k = 0; k < GRP; k++) begin
				if (g * GRP + k < DEPTH) begin
					if (hit[g * GRP + k]) begin
						grp_d[g] = grp_d[g] | words[g * GRP + k];
					end
				end
			end
		end
		final_d = '0;
		for (int g = 0; g < NGRP; g++) begin
			final_d = final_d | grp_s2[g];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_s1 <= 1'b0;
			sel_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			acc_s1 <= accept;
			sel_s2 <= acc_s1;
			done_q <= sel_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_s1) begin
			grp_s2 <= grp_d;
		end
		if (sel_s2) begin
			has_q   <= cursor < count_in;
			value_q <= (cursor < count_in) ? final_d : '0;
			count_q <= count_in;
			rej_q   <= rejected_in;
		end
	end

	assign busy          = acc_s1 | sel_s2;
	assign done          = done_q;
	assign current_value = value_q;
	assign has_item      = has_q;
	assign count         = count_q;
	assign rejected      = rej_q;

`ifndef SYNTHESIS
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({acc_s1, sel_s2, done_q}))
		else $error("more than one item in flight");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc_s1 |-> !accept)
		else $error("item accepted while busy");
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		acc_s1 |=> ##1 done_q)
		else $error("result strobe missing");
`endif

endmodule

// File: rtl/core/cursor_sequence_buffer_top.sv
// Channel   Handshake              Payload
// input     start, accepted when   mode, value
//           start && !busy
// result    done (one cycle)       current_value, has_item, count, rejected
//
// The cell row shifts and the cursor and count update at the accepting edge; the word at
// the cursor is then picked in two registered levels, and done rises together with the result
// of the second level. busy is high while the word is being picked, so the next item
// is taken at the earliest at the edge that ends the done cycle; a new item is not taken
// while one is still being picked. The receiver cannot stall the result.
// arst_n clears the cursor, the count and the control flags; the cells hold no
// meaningful word until written.
module cursor_sequence_buffer_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [2:0]          mode,
	input  logic [31:0]         value,
	output logic                done,
	output logic [31:0]         current_value,
	output logic                has_item,
	output logic [6:0]          count,
	output logic                rejected
);
	import csb_pkg::*;

	logic      accept;
	cell_cmd_t cmd;
	cnt_t      cursor, stored_count;
	logic      rej_state;
	word_t     words [DEPTH];

	assign accept = start && !busy;

	csb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.mode     (mode),
		.value    (value),
		.cmd      (cmd),
		.cursor   (cursor),
		.count    (stored_count),
		.rejected (rej_state)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		word_t left_w, right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = words[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = words[i+1];
		end
		csb_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.idx        (IDX_W'(i)),
			.left_word  (left_w),
			.right_word (right_w),
			.word       (words[i])
		);
	end

	csb_select u_select (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.words         (words),
		.cursor        (cursor),
		.count_in      (stored_count),
		.rejected_in   (rej_state),
		.busy          (busy),
		.done          (done),
		.current_value (current_value),
		.has_item      (has_item),
		.count         (count),
		.rejected      (rejected)
	);

endmodule
